[hdl/tts_pkg.sv]
// Package with shared types and constants of the timer table scheduler.
`timescale 1ns / 1ps
package tts_pkg;
    localparam int NUM_SLOTS_DEFAULT = 16;
    localparam logic [15:0] LATE_LIMIT_RESET = 16'd10;

    localparam logic [2:0] REQ_TICK = 3'd0;
    localparam logic [2:0] REQ_ONESHOT = 3'd1;
    localparam logic [2:0] REQ_PERIODIC = 3'd2;
    localparam logic [2:0] REQ_UNTIL = 3'd3;
    localparam logic [2:0] REQ_STOPPABLE = 3'd4;
    localparam logic [2:0] REQ_STOP = 3'd5;

    localparam logic [2:0] ST_FIRED = 3'd0;
    localparam logic [2:0] ST_REGISTERED = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_STOPPED = 3'd3;
    localparam logic [2:0] ST_STOP_EMPTY = 3'd4;

    localparam logic [1:0] KIND_ONESHOT = 2'd0;
    localparam logic [1:0] KIND_UNTIL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_EMIT,
        S_SINGLE,
        S_WAIT,
        S_FLUSH
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load_req;     // capture the input item
        logic tick;         // advance time and clear scan index
        logic eval_slot;    // act on the slot just read
        logic single;       // do register or stop
        logic push;         // load output register
        logic shift;        // move the new firing into the held result
        logic mark_last;    // the pushed result is the final one of the item
        logic scan_next;    // advance scan index
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic is_tick;
        logic is_single;
        logic scan_done;
        logic slot_fires;
        logic hold_valid;
        logic out_busy;
    } stat_t;
endpackage

[hdl/tts_if.sv]
// Valid/ready channel interfaces of the timer table scheduler.
`timescale 1ns / 1ps
interface tts_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] time_point;
    logic [15:0] period;
    logic [3:0]  stop_slot;
    modport source (output valid, req_type, time_point, period, stop_slot, input ready);
    modport sink (input valid, req_type, time_point, period, stop_slot, output ready);
endinterface

interface tts_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  slot_index;
    logic        late;
    logic [31:0] fire_time;
    logic        last;
    modport source (output valid, status, slot_index, late, fire_time, last, input ready);
    modport sink (input valid, status, slot_index, late, fire_time, last, output ready);
endinterface

interface tts_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[hdl/tts_ram.sv]
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module tts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/tts_datapath.sv]
// Datapath of the timer table scheduler: slot tables, time and output register.
`timescale 1ns / 1ps
module tts_datapath #(
    parameter int NUM_SLOTS = tts_pkg::NUM_SLOTS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tts_pkg::cmd_t  cmd,
    output tts_pkg::stat_t stat,
    tts_req_if.sink        req,
    tts_res_if.source      res,
    tts_cfg_if.sink        cfg
);
    localparam int IW = $clog2(NUM_SLOTS > 1 ? NUM_SLOTS : 2);
    localparam int CW = $clog2(NUM_SLOTS + 1);

    logic [15:0] late_limit_reg;
    logic [31:0] now_reg;
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [2:0]  rtype_reg;
    logic [31:0] tp_reg;
    logic [15:0] per_reg;
    logic [3:0]  stop_reg;
    logic [CW-1:0] idx_reg;
    logic        fire_pend_reg;
    logic        hold_valid_reg;

    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [3:0]  out_slot_reg;
    logic        out_late_reg;
    logic [31:0] out_time_reg;
    logic        out_last_reg;

    // Firing found by the slot just evaluated.
    logic [3:0]  cand_slot_reg;
    logic        cand_late_reg;

    // Result held back until the next firing or the end of the scan, so that the
    // final one can be marked; it also carries a register or stop result.
    logic [2:0]  pend_status_reg;
    logic [3:0]  pend_slot_reg;
    logic        pend_late_reg;

    logic [IW-1:0] idx_w;
    logic [1:0]  kind_q;
    logic [31:0] due_q;
    logic [15:0] per_q;
    logic [31:0] end_q;
    logic [31:0] lateness;
    logic [31:0] end_diff;
    logic        due_hit;
    logic        end_hit;
    logic        slot_ok;

    logic        we;
    logic [IW-1:0] waddr;
    logic [1:0]  kind_w;
    logic [31:0] due_w;
    logic [15:0] per_w;
    logic [31:0] end_w;
    logic        due_we;

    logic [IW:0]   free_idx;
    logic          have_free;
    logic [15:0]   per_fix;
    logic          stop_ok;

    assign idx_w = idx_reg[IW-1:0];
    assign per_fix = (per_reg == 16'd0) ? 16'd1 : per_reg;

    always_comb
    begin
        free_idx = '0;
        have_free = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = (IW+1)'(i);
                have_free = 1'b1;
            end
        end
    end

    assign stop_ok = ({28'd0, stop_reg} < NUM_SLOTS)
                   && valid_reg[stop_reg[IW-1:0]];

    assign lateness = now_reg - due_q;
    assign end_diff = now_reg - end_q;
    assign due_hit = !lateness[31];
    assign end_hit = !end_diff[31];
    assign slot_ok = valid_reg[idx_w];

    // Table writes: registration, or rearm during a tick.
    always_comb
    begin
        we = 1'b0;
        due_we = 1'b0;
        waddr = free_idx[IW-1:0];
        kind_w = 2'(rtype_reg - 3'd1);
        per_w = per_fix;
        end_w = tp_reg;
        due_w = (rtype_reg == tts_pkg::REQ_ONESHOT) ? tp_reg : now_reg + {16'd0, per_fix};
        if (cmd.single && rtype_reg != tts_pkg::REQ_STOP && have_free)
        begin
            we = 1'b1;
            due_we = 1'b1;
        end
        else if (cmd.eval_slot && slot_ok && due_hit && kind_q != tts_pkg::KIND_ONESHOT
                 && !(kind_q == tts_pkg::KIND_UNTIL && end_hit))
        begin
            due_we = 1'b1;
            waddr = idx_w;
            due_w = now_reg + {16'd0, per_q};
        end
    end

    tts_ram #(.WIDTH(2), .DEPTH(NUM_SLOTS)) u_kind (
        .clk(clk), .we(we), .waddr(waddr), .wdata(kind_w), .raddr(idx_w), .rdata(kind_q));
    tts_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_due (
        .clk(clk), .we(due_we), .waddr(waddr), .wdata(due_w), .raddr(idx_w), .rdata(due_q));
    tts_ram #(.WIDTH(16), .DEPTH(NUM_SLOTS)) u_per (
        .clk(clk), .we(we), .waddr(waddr), .wdata(per_w), .raddr(idx_w), .rdata(per_q));
    tts_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_end (
        .clk(clk), .we(we), .waddr(waddr), .wdata(end_w), .raddr(idx_w), .rdata(end_q));

    assign cfg.ready = 1'b1;
    assign req.ready = cmd.load_req;
    assign res.valid = out_valid_reg;
    assign res.status = out_status_reg;
    assign res.slot_index = out_slot_reg;
    assign res.late = out_late_reg;
    assign res.fire_time = out_time_reg;
    assign res.last = out_last_reg;

    assign stat.is_tick = (rtype_reg == tts_pkg::REQ_TICK);
    assign stat.is_single = (rtype_reg >= tts_pkg::REQ_ONESHOT)
                         && (rtype_reg <= tts_pkg::REQ_STOP);
    assign stat.scan_done = (idx_reg == CW'(NUM_SLOTS));
    assign stat.slot_fires = fire_pend_reg;
    assign stat.hold_valid = hold_valid_reg;
    assign stat.out_busy = out_valid_reg && !res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            late_limit_reg <= tts_pkg::LATE_LIMIT_RESET;
            now_reg <= '0;
            valid_reg <= '0;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
            fire_pend_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                late_limit_reg <= cfg.data;
            end
            if (out_valid_reg && res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.tick)
            begin
                now_reg <= now_reg + 32'd1;
                idx_reg <= '0;
                hold_valid_reg <= 1'b0;
            end
            if (cmd.scan_next)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            // The firing flag stays up while the emit step waits on the output.
            if (cmd.shift || (cmd.push && cmd.mark_last))
            begin
                fire_pend_reg <= 1'b0;
            end
            if (cmd.shift)
            begin
                hold_valid_reg <= 1'b1;
            end
            if (cmd.push && cmd.mark_last)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (cmd.eval_slot && slot_ok && due_hit)
            begin
                if (kind_q == tts_pkg::KIND_UNTIL && end_hit)
                begin
                    valid_reg[idx_w] <= 1'b0;
                end
                else
                begin
                    fire_pend_reg <= 1'b1;
                    if (kind_q == tts_pkg::KIND_ONESHOT)
                    begin
                        valid_reg[idx_w] <= 1'b0;
                    end
                end
            end
            if (cmd.single)
            begin
                fire_pend_reg <= 1'b1;
                if (rtype_reg == tts_pkg::REQ_STOP)
                begin
                    if (stop_ok)
                    begin
                        valid_reg[stop_reg[IW-1:0]] <= 1'b0;
                    end
                end
                else if (have_free)
                begin
                    valid_reg[free_idx[IW-1:0]] <= 1'b1;
                end
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req && req.valid)
        begin
            rtype_reg <= req.req_type;
            tp_reg <= req.time_point;
            per_reg <= req.period;
            stop_reg <= req.stop_slot;
        end
        if (cmd.eval_slot)
        begin
            cand_slot_reg <= 4'(idx_w);
            cand_late_reg <= (lateness > {16'd0, late_limit_reg});
        end
        if (cmd.shift)
        begin
            pend_status_reg <= tts_pkg::ST_FIRED;
            pend_slot_reg <= cand_slot_reg;
            pend_late_reg <= cand_late_reg;
        end
        if (cmd.single)
        begin
            pend_late_reg <= 1'b0;
            if (rtype_reg == tts_pkg::REQ_STOP)
            begin
                pend_status_reg <= stop_ok ? tts_pkg::ST_STOPPED : tts_pkg::ST_STOP_EMPTY;
                pend_slot_reg <= stop_reg;
            end
            else if (have_free)
            begin
                pend_status_reg <= tts_pkg::ST_REGISTERED;
                pend_slot_reg <= 4'(free_idx);
            end
            else
            begin
                pend_status_reg <= tts_pkg::ST_FULL;
                pend_slot_reg <= 4'd0;
            end
        end
        if (cmd.push)
        begin
            out_status_reg <= pend_status_reg;
            out_slot_reg <= pend_slot_reg;
            out_late_reg <= pend_late_reg;
            out_time_reg <= now_reg;
            out_last_reg <= cmd.mark_last;
        end
    end

`ifndef SYNTHESIS
    a_late_only_fired: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.late |-> res.status == tts_pkg::ST_FIRED)
        else $error("late set on a non-fired result");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= CW'(NUM_SLOTS))
        else $error("scan index out of range");
    a_no_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !stat.out_busy)
        else $error("output overwritten");
`endif
endmodule

[hdl/tts_ctrl.sv]
// Controller state machine of the timer table scheduler.
`timescale 1ns / 1ps
module tts_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  tts_pkg::stat_t stat,
    output tts_pkg::cmd_t  cmd
);
    tts_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // S_WAIT follows capture so the request decode is registered.
    // During a tick each firing is held back until the next one is found, and the
    // last one leaves through S_FLUSH with the final flag.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tts_pkg::S_IDLE:
                if (req_valid) state_next = tts_pkg::S_WAIT;
            tts_pkg::S_WAIT:
                if (stat.is_tick) state_next = tts_pkg::S_SCAN;
                else if (stat.is_single) state_next = tts_pkg::S_SINGLE;
                else state_next = tts_pkg::S_IDLE;
            tts_pkg::S_SCAN:
                if (stat.scan_done)
                    state_next = stat.hold_valid ? tts_pkg::S_FLUSH : tts_pkg::S_IDLE;
                else state_next = tts_pkg::S_EVAL;
            tts_pkg::S_EVAL:
                state_next = tts_pkg::S_EMIT;
            tts_pkg::S_EMIT:
                if (stat.is_single)
                begin
                    if (!stat.out_busy) state_next = tts_pkg::S_IDLE;
                end
                else if (!stat.slot_fires || !(stat.hold_valid && stat.out_busy))
                    state_next = tts_pkg::S_SCAN;
            tts_pkg::S_SINGLE:
                state_next = tts_pkg::S_EMIT;
            tts_pkg::S_FLUSH:
                if (!stat.out_busy) state_next = tts_pkg::S_IDLE;
            default:
                state_next = tts_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            tts_pkg::S_IDLE:
                cmd.load_req = 1'b1;
            tts_pkg::S_WAIT:
                cmd.tick = stat.is_tick;
            tts_pkg::S_EVAL:
            begin
                cmd.eval_slot = 1'b1;
                cmd.scan_next = 1'b1;
            end
            tts_pkg::S_EMIT:
                if (stat.is_single)
                begin
                    cmd.push = stat.slot_fires && !stat.out_busy;
                    cmd.mark_last = 1'b1;
                end
                else if (stat.slot_fires && !(stat.hold_valid && stat.out_busy))
                begin
                    cmd.shift = 1'b1;
                    cmd.push = stat.hold_valid;
                end
            tts_pkg::S_SINGLE:
                cmd.single = 1'b1;
            tts_pkg::S_FLUSH:
            begin
                cmd.push = !stat.out_busy;
                cmd.mark_last = 1'b1;
            end
            default:
                cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.tick, cmd.eval_slot, cmd.single, cmd.push}))
        else $error("conflicting commands");
    a_eval_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tts_pkg::S_EVAL |=> state_reg == tts_pkg::S_EMIT)
        else $error("evaluation not followed by emit");
    a_single_flag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.single |=> stat.slot_fires)
        else $error("single request produced no result");
`endif
endmodule

[hdl/timer_table_scheduler_core.sv]
// Top level of the timer table scheduler.
`timescale 1ns / 1ps
//  Channel | Direction | Payload
//  req     | in        | req_type, time_point, period, stop_slot
//  res     | out       | status, slot_index, late, fire_time, last
//  cfg     | in        | data (late_limit)
//
// A register or stop request is accepted, decoded, carried out and then emitted; its
// result transaction is registered, and the emit step waits while the output is busy.
// A tick is accepted and decoded, then each of the NUM_SLOTS slots (16 by default) gets
// a read, evaluate and emit step; a final scan check follows and, if any slot fired, a
// flush of the last firing, which is held back so that it can carry the last flag.
// Reset is asynchronous and active low; it clears time and all valid bits.
// A stalled result channel holds the scan at the emit step of the next firing slot,
// or at the flush. The configuration channel is always ready.
module timer_table_scheduler_core #(
    parameter int NUM_SLOTS = tts_pkg::NUM_SLOTS_DEFAULT
) (
    input logic       clk,
    input logic       rst_n,
    tts_req_if.sink   req,
    tts_res_if.source res,
    tts_cfg_if.sink   cfg
);
    tts_pkg::cmd_t  cmd;
    tts_pkg::stat_t stat;

    // The controller sequences each request; the datapath holds all storage.
    tts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .req_valid(req.valid), .stat(stat), .cmd(cmd));

    tts_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .req(req), .res(res), .cfg(cfg));
endmodule
